// ===== hdl/pri_pkg.sv =====
// shared constants for the point rotate and isometric projection block
package pri_pkg;

   // field widths
   localparam int IN_W    = 16;
   localparam int COEF_W  = 16;
   localparam int SCR_W   = 24;
   localparam int DEPTH_W = 18;

   // configuration port
   localparam int NUM_REGS   = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = COEF_W;

   localparam logic [CSR_IDX_W-1:0] REG_COS_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COS_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COS_Z = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_Z = 3'd5;

   // fixed point
   localparam int FRAC_W  = 14;
   localparam int RND_Q14 = 8192;
   localparam int ONE_Q14 = 16384;
   localparam int ISO_COS = 14189;

   localparam logic signed [COEF_W-1:0] COS_RESET = COEF_W'(ONE_Q14);
   localparam logic signed [COEF_W-1:0] SIN_RESET = '0;

   // each rotation grows the coordinate by this many bits
   localparam int ROT_GROW = COEF_W + 1 - FRAC_W;

   // screen scaling
   localparam int SCALE_FRAC = 8;
   localparam int RND_SCALE  = 128;
   localparam int SCREEN_WIDTH_DEF  = 1024;
   localparam int SCREEN_HEIGHT_DEF = 768;

   // output limits
   localparam int SCR_MAX   = (1 << (SCR_W - 1)) - 1;
   localparam int SCR_MIN   = -(1 << (SCR_W - 1));
   localparam int DEPTH_MAX = (1 << (DEPTH_W - 1)) - 1;
   localparam int DEPTH_MIN = -(1 << (DEPTH_W - 1));

endpackage

// ===== hdl/pri_req_if.sv =====
// point request channel
interface pri_req_if;
   logic valid;
   logic ready;
   logic signed [pri_pkg::IN_W-1:0] in_x;
   logic signed [pri_pkg::IN_W-1:0] in_y;
   logic signed [pri_pkg::IN_W-1:0] in_z;

   modport source (output valid, output in_x, output in_y, output in_z, input ready);
   modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

// ===== hdl/pri_rsp_if.sv =====
// projected point response channel
interface pri_rsp_if;
   logic valid;
   logic ready;
   logic signed [pri_pkg::SCR_W-1:0]   screen_x;
   logic signed [pri_pkg::SCR_W-1:0]   screen_y;
   logic signed [pri_pkg::DEPTH_W-1:0] depth_z;

   modport source (output valid, output screen_x, output screen_y, output depth_z,
                   input ready);
   modport sink   (input valid, input screen_x, input screen_y, input depth_z,
                   output ready);
endinterface

// ===== hdl/pri_rot.sv =====
// one plane rotation: multiply stage then add and round stage
module pri_rot #(
   parameter int WI = 16,
   parameter int WC = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               vld_i,
   output logic                               rdy_o,
   input  logic signed [WI-1:0]               a_i,
   input  logic signed [WI-1:0]               b_i,
   input  logic signed [WC-1:0]               c_i,
   input  logic signed [pri_pkg::COEF_W-1:0]  cos_i,
   input  logic signed [pri_pkg::COEF_W-1:0]  sin_i,
   output logic                               vld_o,
   input  logic                               rdy_i,
   output logic signed [WI+pri_pkg::ROT_GROW-1:0] a_o,
   output logic signed [WI+pri_pkg::ROT_GROW-1:0] b_o,
   output logic signed [WC-1:0]               c_o
);
   import pri_pkg::*;

   localparam int PW = WI + COEF_W;
   localparam int SW = PW + 1;
   localparam int OW = SW - FRAC_W;

   logic [2:1] v_ff;
   logic [2:1] en;

   logic signed [PW-1:0] p_ac_in, p_bs_in, p_as_in, p_bc_in;
   logic signed [PW-1:0] p_ac_ff, p_bs_ff, p_as_ff, p_bc_ff;
   logic signed [WC-1:0] c1_ff, c2_ff;
   logic signed [SW-1:0] sa, sb;
   logic signed [OW-1:0] a2_in, b2_in, a2_ff, b2_ff;

   // stage moves when empty or when the next one moves
   always_comb begin
      en[2] = !v_ff[2] || rdy_i;
      en[1] = !v_ff[1] || en[2];
   end

   assign rdy_o = en[1];
   assign vld_o = v_ff[2];

   always_comb begin
      p_ac_in = PW'(a_i) * PW'(cos_i);
      p_bs_in = PW'(b_i) * PW'(sin_i);
      p_as_in = PW'(a_i) * PW'(sin_i);
      p_bc_in = PW'(b_i) * PW'(cos_i);
   end

   // round half up, floor shift
   always_comb begin
      sa    = SW'(p_ac_ff) - SW'(p_bs_ff) + SW'(RND_Q14);
      sb    = SW'(p_as_ff) + SW'(p_bc_ff) + SW'(RND_Q14);
      a2_in = sa[SW-1:FRAC_W];
      b2_in = sb[SW-1:FRAC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) v_ff[1] <= vld_i;
         if (en[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         p_ac_ff <= p_ac_in;
         p_bs_ff <= p_bs_in;
         p_as_ff <= p_as_in;
         p_bc_ff <= p_bc_in;
         c1_ff   <= c_i;
      end
      if (en[2]) begin
         a2_ff <= a2_in;
         b2_ff <= b2_in;
         c2_ff <= c1_ff;
      end
   end

   assign a_o = a2_ff;
   assign b_o = b2_ff;
   assign c_o = c2_ff;

endmodule

// ===== hdl/pri_proj.sv =====
// isometric projection, screen scaling and output saturation
module pri_proj #(
   parameter int WI            = 25,
   parameter int WZ            = 22,
   parameter int SCREEN_WIDTH  = pri_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = pri_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                vld_i,
   output logic                                rdy_o,
   input  logic signed [WI-1:0]                x_i,
   input  logic signed [WI-1:0]                y_i,
   input  logic signed [WZ-1:0]                z_i,
   output logic                                vld_o,
   input  logic                                rdy_i,
   output logic signed [pri_pkg::SCR_W-1:0]    screen_x_o,
   output logic signed [pri_pkg::SCR_W-1:0]    screen_y_o,
   output logic signed [pri_pkg::DEPTH_W-1:0]  depth_z_o
);
   import pri_pkg::*;

   localparam int NST    = 5;
   localparam int DW     = WI + 1;
   localparam int PXW    = DW + COEF_W;
   localparam int OW     = PXW + 1 - FRAC_W;
   localparam int DIM_MX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
   localparam int DIM_W  = $clog2(DIM_MX + 1) + 1;
   localparam int MW     = OW + DIM_W;
   localparam int RW     = MW + 1 - SCALE_FRAC;
   localparam int PX_OFS = RND_Q14 + (ONE_Q14 << FRAC_W);

   localparam logic signed [DIM_W-1:0] SCALE_X = DIM_W'(SCREEN_WIDTH);
   localparam logic signed [DIM_W-1:0] SCALE_Y = DIM_W'(SCREEN_HEIGHT);

   logic [NST:1] v_ff;
   logic [NST:1] en;

   // stage 1: difference and sum
   logic signed [DW-1:0]  d_ff, s_ff;
   logic signed [WZ-1:0]  z1_ff, z2_ff, z3_ff, z4_ff;
   // stage 2: iso multiply, half sum minus depth
   logic signed [PXW-1:0] pxp_in, pxp_ff;
   logic signed [DW:0]    t_sum;
   logic signed [DW-1:0]  half;
   logic signed [DW:0]    py_in, py_ff;
   // stage 3: round and recenter
   logic signed [PXW:0]   pxs;
   logic signed [OW-1:0]  pxo_in, pxo_ff, pyo_in, pyo_ff;
   // stage 4: scale
   logic signed [MW-1:0]  mx_in, my_in, mx_ff, my_ff;
   // stage 5: round and clamp
   logic signed [MW:0]    rx, ry;
   logic signed [RW-1:0]  rx_sh, ry_sh;
   logic signed [SCR_W-1:0]   sx_in, sy_in, sx_ff, sy_ff;
   logic signed [DEPTH_W-1:0] dz_in, dz_ff;

   always_comb begin
      en[NST] = !v_ff[NST] || rdy_i;
      for (int i = NST - 1; i >= 1; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign rdy_o = en[1];
   assign vld_o = v_ff[NST];

   always_comb begin
      pxp_in = PXW'(d_ff) * PXW'(ISO_COS);
      t_sum  = (DW+1)'(s_ff) + (DW+1)'(1);
      half   = t_sum[DW:1];
      py_in  = (DW+1)'(half) - (DW+1)'(z1_ff);
   end

   // rounding offset and the +1.0 recentering fold into one add
   always_comb begin
      pxs    = (PXW+1)'(pxp_ff) + (PXW+1)'(PX_OFS);
      pxo_in = pxs[PXW:FRAC_W];
      pyo_in = OW'(py_ff) + OW'(ONE_Q14);
   end

   always_comb begin
      mx_in = MW'(pxo_ff) * MW'(SCALE_X);
      my_in = MW'(pyo_ff) * MW'(SCALE_Y);
   end

   always_comb begin
      rx    = (MW+1)'(mx_ff) + (MW+1)'(RND_SCALE);
      ry    = (MW+1)'(my_ff) + (MW+1)'(RND_SCALE);
      rx_sh = rx[MW:SCALE_FRAC];
      ry_sh = ry[MW:SCALE_FRAC];

      if (rx_sh > RW'(SCR_MAX)) begin
         sx_in = SCR_W'(SCR_MAX);
      end else if (rx_sh < RW'(SCR_MIN)) begin
         sx_in = SCR_W'(SCR_MIN);
      end else begin
         sx_in = rx_sh[SCR_W-1:0];
      end

      if (ry_sh > RW'(SCR_MAX)) begin
         sy_in = SCR_W'(SCR_MAX);
      end else if (ry_sh < RW'(SCR_MIN)) begin
         sy_in = SCR_W'(SCR_MIN);
      end else begin
         sy_in = ry_sh[SCR_W-1:0];
      end

      if (z4_ff > WZ'(DEPTH_MAX)) begin
         dz_in = DEPTH_W'(DEPTH_MAX);
      end else if (z4_ff < WZ'(DEPTH_MIN)) begin
         dz_in = DEPTH_W'(DEPTH_MIN);
      end else begin
         dz_in = z4_ff[DEPTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) v_ff[1] <= vld_i;
         for (int i = 2; i <= NST; i++) begin
            if (en[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         d_ff  <= DW'(x_i) - DW'(y_i);
         s_ff  <= DW'(x_i) + DW'(y_i);
         z1_ff <= z_i;
      end
      if (en[2]) begin
         pxp_ff <= pxp_in;
         py_ff  <= py_in;
         z2_ff  <= z1_ff;
      end
      if (en[3]) begin
         pxo_ff <= pxo_in;
         pyo_ff <= pyo_in;
         z3_ff  <= z2_ff;
      end
      if (en[4]) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
         z4_ff <= z3_ff;
      end
      if (en[5]) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         dz_ff <= dz_in;
      end
   end

   assign screen_x_o = sx_ff;
   assign screen_y_o = sy_ff;
   assign depth_z_o  = dz_ff;

endmodule

// ===== hdl/point_rotate_iso_project_top.sv =====
// top level: euler rotation and isometric projection pipeline
// Takes one point per transaction in signed Q1.14, rotates it about X, then Y, then Z
// with the six Q1.14 sine/cosine registers, projects it isometrically at 30 degrees and
// returns screen x and y with 6 fraction bits plus the rotated depth with 14 fraction
// bits, all saturated. The block accepts one transaction every clock while the response
// side keeps taking them. Three rotation units of two stages each (a multiply stage
// and an add-and-round stage) are followed by a five stage projection and scaling unit
// whose last stage is the output register. Every stage holds its own valid bit, so a
// stalled response backs up only the stages that are full and empty stages keep
// taking new points. Rotation registers are to be written through the csr port only
// while no transaction is in flight; the block itself does not enforce this. Writes
// to index six or seven are dropped.
module point_rotate_iso_project_top #(
   parameter int SCREEN_WIDTH  = pri_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = pri_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   pri_req_if.sink                            req_ch,
   pri_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [pri_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pri_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pri_pkg::*;

   // coordinate widths after each rotation
   localparam int W0 = IN_W;
   localparam int W1 = W0 + ROT_GROW;
   localparam int W2 = W1 + ROT_GROW;
   localparam int W3 = W2 + ROT_GROW;

   // rotation registers
   logic signed [COEF_W-1:0] cfg_ff [NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_COS_X] <= COS_RESET;
         cfg_ff[REG_SIN_X] <= SIN_RESET;
         cfg_ff[REG_COS_Y] <= COS_RESET;
         cfg_ff[REG_SIN_Y] <= SIN_RESET;
         cfg_ff[REG_COS_Z] <= COS_RESET;
         cfg_ff[REG_SIN_Z] <= SIN_RESET;
      end else if (csr_we && (csr_index < CSR_IDX_W'(NUM_REGS))) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // handshake chain between units
   logic vld_rx, rdy_rx;
   logic vld_ry, rdy_ry;
   logic vld_rz, rdy_rz;
   logic rdy_pj;

   // coordinates between units
   logic signed [W0-1:0] x_s1;
   logic signed [W1-1:0] y_s1, z_s1;
   logic signed [W1-1:0] y_s2;
   logic signed [W2-1:0] x_s2, z_s2;
   logic signed [W2-1:0] z_s3;
   logic signed [W3-1:0] x_s3, y_s3;

   // about X: y' = y*cx - z*sx, z' = y*sx + z*cx
   pri_rot #(
      .WI (W0),
      .WC (W0)
   ) u_rot_x (
      .clock (clock),
      .reset (reset),
      .vld_i (req_ch.valid),
      .rdy_o (rdy_rx),
      .a_i   (req_ch.in_y),
      .b_i   (req_ch.in_z),
      .c_i   (req_ch.in_x),
      .cos_i (cfg_ff[REG_COS_X]),
      .sin_i (cfg_ff[REG_SIN_X]),
      .vld_o (vld_rx),
      .rdy_i (rdy_ry),
      .a_o   (y_s1),
      .b_o   (z_s1),
      .c_o   (x_s1)
   );

   assign req_ch.ready = rdy_rx;

   // about Y: z' = z*cy - x*sy, x' = z*sy + x*cy
   pri_rot #(
      .WI (W1),
      .WC (W1)
   ) u_rot_y (
      .clock (clock),
      .reset (reset),
      .vld_i (vld_rx),
      .rdy_o (rdy_ry),
      .a_i   (z_s1),
      .b_i   (W1'(x_s1)),
      .c_i   (y_s1),
      .cos_i (cfg_ff[REG_COS_Y]),
      .sin_i (cfg_ff[REG_SIN_Y]),
      .vld_o (vld_ry),
      .rdy_i (rdy_rz),
      .a_o   (z_s2),
      .b_o   (x_s2),
      .c_o   (y_s2)
   );

   // about Z: x' = x*cz - y*sz, y' = x*sz + y*cz
   pri_rot #(
      .WI (W2),
      .WC (W2)
   ) u_rot_z (
      .clock (clock),
      .reset (reset),
      .vld_i (vld_ry),
      .rdy_o (rdy_rz),
      .a_i   (x_s2),
      .b_i   (W2'(y_s2)),
      .c_i   (z_s2),
      .cos_i (cfg_ff[REG_COS_Z]),
      .sin_i (cfg_ff[REG_SIN_Z]),
      .vld_o (vld_rz),
      .rdy_i (rdy_pj),
      .a_o   (x_s3),
      .b_o   (y_s3),
      .c_o   (z_s3)
   );

   // isometric projection, screen scaling, clamp, output register
   pri_proj #(
      .WI            (W3),
      .WZ            (W2),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_proj (
      .clock      (clock),
      .reset      (reset),
      .vld_i      (vld_rz),
      .rdy_o      (rdy_pj),
      .x_i        (x_s3),
      .y_i        (y_s3),
      .z_i        (z_s3),
      .vld_o      (rsp_ch.valid),
      .rdy_i      (rsp_ch.ready),
      .screen_x_o (rsp_ch.screen_x),
      .screen_y_o (rsp_ch.screen_y),
      .depth_z_o  (rsp_ch.depth_z)
   );

endmodule

// ===== hdl/pri_checker.sv =====
// port level checks for the rotation and projection top level, with its bind
module pri_port_checks (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [pri_pkg::SCR_W-1:0]   rsp_screen_x,
   input logic signed [pri_pkg::SCR_W-1:0]   rsp_screen_y,
   input logic signed [pri_pkg::DEPTH_W-1:0] rsp_depth_z
);

   // pipeline comes out of reset empty
   a_empty_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a free output slot lets every stage move, so requests are taken
   a_ready_when_free : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled while output is free");

   // with the response side ready in both cycles, a taken request never makes the input stall next cycle
   a_no_stall_on_flow : assert property (@(posedge clock) disable iff (reset)
      ($past(req_valid && req_ready && rsp_ready) && rsp_ready) |-> req_ready)
      else $error("request stalled while response side keeps flowing");

   // a waiting transaction holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_screen_x)
                                     && $stable(rsp_screen_y) && $stable(rsp_depth_z)))
      else $error("response changed while stalled");

endmodule

bind point_rotate_iso_project_top pri_port_checks u_pri_port_checks (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_screen_x (rsp_ch.screen_x),
   .rsp_screen_y (rsp_ch.screen_y),
   .rsp_depth_z  (rsp_ch.depth_z)
);

// ===== verif/pri_checker.sv =====
`timescale 1ns / 1ps
// projection checker: watches the channels, predicts each projected point and compares
module pri_checker
   import pri_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   pri_req_if                    req_mon,
   pri_rsp_if                    rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           points_in,
   output int unsigned           points_out,
   output int unsigned           mismatches,
   output int unsigned           depth_clamps
);

   localparam longint ISO_SIN_Q14 = ONE_Q14 / 2;

   typedef struct packed {
      logic signed [SCR_W-1:0]   screen_x;
      logic signed [SCR_W-1:0]   screen_y;
      logic signed [DEPTH_W-1:0] depth_z;
   } proj_type;

   logic signed [COEF_W-1:0] coef [NUM_REGS];
   proj_type                 proj_q [$];
   int unsigned              fail_n  = 0;
   int unsigned              clamp_n = 0;

   assign mismatches   = fail_n;
   assign depth_clamps = clamp_n;

   // round half up, floor shift
   function automatic longint rnd_shift(input longint v, input int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic proj_type project_point(input logic signed [IN_W-1:0] x_in,
                                              input logic signed [IN_W-1:0] y_in,
                                              input logic signed [IN_W-1:0] z_in,
                                              output bit depth_clamped);
      longint   x, y, z, t, px, py;
      longint   cx, sx, cy, sy, cz, sz;
      proj_type r;
      cx = coef[REG_COS_X];
      sx = coef[REG_SIN_X];
      cy = coef[REG_COS_Y];
      sy = coef[REG_SIN_Y];
      cz = coef[REG_COS_Z];
      sz = coef[REG_SIN_Z];
      x  = x_in;
      y  = y_in;
      z  = z_in;
      // about x
      t = rnd_shift(y * cx - z * sx, FRAC_W);
      z = rnd_shift(y * sx + z * cx, FRAC_W);
      y = t;
      // about y
      t = rnd_shift(x * cy + z * sy, FRAC_W);
      z = rnd_shift(z * cy - x * sy, FRAC_W);
      x = t;
      // about z
      t = rnd_shift(x * cz - y * sz, FRAC_W);
      y = rnd_shift(x * sz + y * cz, FRAC_W);
      x = t;
      // isometric projection and screen scaling
      px = rnd_shift((x - y) * ISO_COS, FRAC_W);
      py = rnd_shift((x + y) * ISO_SIN_Q14, FRAC_W) - z;
      r.screen_x = SCR_W'(clamp(rnd_shift((px + ONE_Q14) * SCREEN_WIDTH, SCALE_FRAC),
                                SCR_MIN, SCR_MAX));
      r.screen_y = SCR_W'(clamp(rnd_shift((py + ONE_Q14) * SCREEN_HEIGHT, SCALE_FRAC),
                                SCR_MIN, SCR_MAX));
      r.depth_z  = DEPTH_W'(clamp(z, DEPTH_MIN, DEPTH_MAX));
      depth_clamped = (z > DEPTH_MAX) || (z < DEPTH_MIN);
      return r;
   endfunction

   task automatic note_field(input string field, input longint want, input longint got);
      fail_n++;
      if (fail_n <= 10)
         $display("point %0d %s: expected %0d, got %0d", points_out, field, want, got);
   endtask

   always @(posedge clock) begin
      proj_type want;
      bit       clamped;
      if (reset) begin
         coef[REG_COS_X] = COS_RESET;
         coef[REG_SIN_X] = SIN_RESET;
         coef[REG_COS_Y] = COS_RESET;
         coef[REG_SIN_Y] = SIN_RESET;
         coef[REG_COS_Z] = COS_RESET;
         coef[REG_SIN_Z] = SIN_RESET;
         proj_q.delete();
         points_in  <= 0;
         points_out <= 0;
      end else begin
         if (csr_we && csr_index < NUM_REGS)
            coef[csr_index] = csr_wdata;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (proj_q.size() == 0) begin
               fail_n++;
               if (fail_n <= 10)
                  $display("unrequested response: screen_x %0d screen_y %0d depth_z %0d",
                           rsp_mon.screen_x, rsp_mon.screen_y, rsp_mon.depth_z);
            end else begin
               want = proj_q.pop_front();
               if (rsp_mon.screen_x !== want.screen_x)
                  note_field("screen_x", want.screen_x, rsp_mon.screen_x);
               if (rsp_mon.screen_y !== want.screen_y)
                  note_field("screen_y", want.screen_y, rsp_mon.screen_y);
               if (rsp_mon.depth_z !== want.depth_z)
                  note_field("depth_z", want.depth_z, rsp_mon.depth_z);
            end
            points_out <= points_out + 1;
         end
         if (req_mon.valid && req_mon.ready) begin
            proj_q.push_back(project_point(req_mon.in_x, req_mon.in_y, req_mon.in_z,
                                           clamped));
            if (clamped) clamp_n++;
            points_in <= points_in + 1;
         end
      end
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// testbench top: drives points and coefficient writes into the projection block
module tb;
   import pri_pkg::*;

   localparam int RAND_PHASES = 12;
   localparam int PHASE_ITEMS = 150;
   localparam int LONG_HOLD   = 64;   // response hold-off, well past the pipeline depth
   localparam int TAIL_CYCLES = 40;   // leave room for strays

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // idle_on enables random gaps on both sides, hold_req asks the receiver for a long stall
   logic                  idle_on;
   int unsigned           hold_req;
   int unsigned           settings_n;
   int unsigned           holds_done;

   int unsigned points_in, points_out, mismatches, depth_clamps;

   pri_req_if req_bus ();
   pri_rsp_if rsp_bus ();

   point_rotate_iso_project_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pri_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .points_in    (points_in),
      .points_out   (points_out),
      .mismatches   (mismatches),
      .depth_clamps (depth_clamps)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // single synchronous reset at the start of the run
   initial begin
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // overall limit, far beyond the slowest legal run
   initial begin
      #4ms;
      $display("timeout: %0d points sent, %0d responses seen", points_in, points_out);
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // response side: random stalls, plus a long hold-off whenever one is asked for
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned hold;
      int unsigned hold_seen;
      hold_seen = 0;
      holds_done = 0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         hold = 0;
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold = LONG_HOLD;
            holds_done++;
         end else if (idle_on) begin
            hold = $urandom_range(0, 8);
         end
         if (hold != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         // hold ready until a transaction goes through
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------------
   // request side helpers
   // ---------------------------------------------------------------------------

   // one point transaction; valid stays high across back-to-back points
   task automatic send_point(input logic [IN_W-1:0] x, input logic [IN_W-1:0] y,
                             input logic [IN_W-1:0] z);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_x  <= x;
      req_bus.in_y  <= y;
      req_bus.in_z  <= z;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // stop offering points and wait until every response is back
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (points_in != points_out) @(posedge clock);
   endtask

   // register write, one per clock; caller drops csr_we afterwards
   task automatic write_coef(input logic [CSR_IDX_W-1:0] idx,
                             input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // mostly legal q1.14 values, with the range ends and raw 16-bit patterns mixed in
   function automatic logic [CSR_DATA_W-1:0] pick_coef();
      int v;
      case ($urandom_range(0, 11))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return CSR_DATA_W'(ONE_Q14);
         3: return CSR_DATA_W'(-ONE_Q14);
         4: return '0;
         5, 6: return CSR_DATA_W'($urandom());
         default: begin
            v = int'($urandom_range(0, 2 * ONE_Q14)) - ONE_Q14;
            return CSR_DATA_W'(v);
         end
      endcase
   endfunction

   function automatic logic [IN_W-1:0] pick_field();
      case ($urandom_range(0, 15))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return '0;
         default: return IN_W'($urandom());
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus and verdict
   // ---------------------------------------------------------------------------
   initial begin
      int dir_pts [12][3];
      int k, n, r;
      logic [IN_W-1:0] lo, hi;

      dir_pts = '{'{0, 0, 0}, '{32767, 32767, 32767}, '{-32768, -32768, -32768},
                  '{32767, -32768, 0}, '{-32768, 32767, 0}, '{0, 0, 32767},
                  '{0, 0, -32768}, '{16384, 0, 0}, '{0, 16384, 0}, '{1, -1, 1},
                  '{-1, 1, -1}, '{8192, -8192, 16384}};
      lo = 16'h8000;
      hi = 16'h7FFF;

      req_bus.valid <= 1'b0;
      req_bus.in_x  <= '0;
      req_bus.in_y  <= '0;
      req_bus.in_z  <= '0;
      csr_we        <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      idle_on       <= 1'b0;
      hold_req      <= 0;
      settings_n     = 1;
      do @(posedge clock); while (reset);

      // identity rotation straight out of reset, no register written yet
      for (n = 0; n < 12; n++)
         send_point(IN_W'(dir_pts[n][0]), IN_W'(dir_pts[n][1]), IN_W'(dir_pts[n][2]));
      drain();

      // every coefficient at the negative end (-2.0): depth clamps on the corners;
      // writes to the unused indexes must leave the registers alone
      idle_on <= 1'b1;
      for (r = 0; r < NUM_REGS; r++) write_coef(CSR_IDX_W'(r), 16'h8000);
      write_coef(CSR_IDX_W'(NUM_REGS), CSR_DATA_W'($urandom()));
      write_coef(CSR_IDX_W'(NUM_REGS + 1), CSR_DATA_W'($urandom()));
      csr_we <= 1'b0;
      settings_n++;
      for (n = 0; n < 8; n++)
         send_point(n[0] ? hi : lo, n[1] ? hi : lo, n[2] ? hi : lo);
      drain();

      // every coefficient at the positive end
      for (r = 0; r < NUM_REGS; r++) write_coef(CSR_IDX_W'(r), 16'h7FFF);
      csr_we <= 1'b0;
      settings_n++;
      send_point(hi, hi, hi);
      send_point(lo, lo, lo);
      send_point(hi, lo, hi);
      send_point(lo, hi, lo);
      drain();

      // random phases, each with a fresh coefficient set; every third phase runs
      // without gaps on either side
      for (k = 0; k < RAND_PHASES; k++) begin
         idle_on <= (k % 3 != 0);
         for (r = 0; r < NUM_REGS; r++) begin
            if (k == RAND_PHASES - 1)
               write_coef(CSR_IDX_W'(r), r[0] ? SIN_RESET : COS_RESET);
            else
               write_coef(CSR_IDX_W'(r), pick_coef());
         end
         if ($urandom_range(0, 3) == 0)
            write_coef(CSR_IDX_W'(NUM_REGS + $urandom_range(0, 1)), CSR_DATA_W'($urandom()));
         csr_we <= 1'b0;
         settings_n++;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            send_point(pick_field(), pick_field(), pick_field());
            // long response stall while points keep coming: pipeline fills and
            // back-pressure reaches the request side
            if ((k == 1 || k == 3) && n == PHASE_ITEMS / 3)
               hold_req <= hold_req + 1;
            // sender goes quiet mid-phase until everything is back
            if (k == 2 && n == PHASE_ITEMS / 2)
               drain();
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("summary: %0d points projected under %0d coefficient settings",
               points_in, settings_n);
      $display("summary: %0d with clamped depth, %0d long response stalls, %0d responses",
               depth_clamps, holds_done, points_out);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/pri_pkg.sv
hdl/pri_req_if.sv
hdl/pri_rsp_if.sv
hdl/pri_rot.sv
hdl/pri_proj.sv
hdl/point_rotate_iso_project_top.sv
hdl/pri_checker.sv
verif/pri_checker.sv
verif/tb.sv
